// ===== rtl/pce_pkg.sv =====
// Shared types, constants and helper functions of the parametric CRC engine.
package pce_pkg;

  localparam int CRC_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int ORDER_W = 6;
  localparam int IDX_W   = 3;
  localparam int TOP_W   = 5;

  localparam logic [ORDER_W-1:0] ORDER_MIN = 6'd1;
  localparam logic [ORDER_W-1:0] ORDER_MAX = 6'd32;
  localparam logic [ORDER_W-1:0] ORDER_RST = 6'd16;
  localparam logic [CRC_W-1:0]   POLY_RST  = 32'h0000_8408;

  localparam logic [IDX_W-1:0] REG_ORDER       = 3'd0;
  localparam logic [IDX_W-1:0] REG_POLY        = 3'd1;
  localparam logic [IDX_W-1:0] REG_INIT        = 3'd2;
  localparam logic [IDX_W-1:0] REG_INIT_DIRECT = 3'd3;
  localparam logic [IDX_W-1:0] REG_FINAL_XOR   = 3'd4;
  localparam logic [IDX_W-1:0] REG_REFL_IN     = 3'd5;
  localparam logic [IDX_W-1:0] REG_REFL_OUT    = 3'd6;

  typedef struct packed {
    logic adv;
    logic reload;
  } cell_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_st_t;

  function automatic logic [ORDER_W-1:0] eff_order(input logic [ORDER_W-1:0] o);
    logic [ORDER_W-1:0] r;
    r = o;
    if (o < ORDER_MIN) r = ORDER_MIN;
    if (o > ORDER_MAX) r = ORDER_MAX;
    return r;
  endfunction

  function automatic logic [CRC_W-1:0] width_mask(input logic [ORDER_W-1:0] n);
    logic [CRC_W-1:0] m;
    for (int i = 0; i < CRC_W; i++) begin
      m[i] = (ORDER_W'(i) < n);
    end
    return m;
  endfunction

  function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = v[BYTE_W-1-i];
    end
    return r;
  endfunction

  function automatic logic [CRC_W-1:0] rev32(input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    for (int i = 0; i < CRC_W; i++) begin
      r[i] = v[CRC_W-1-i];
    end
    return r;
  endfunction

endpackage

// ===== rtl/pce_cell.sv =====
// One bit slice of the running CRC: holds its bit and forms its eight shift steps.
module pce_cell
  import pce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic              start_bit,
  input  logic              en,
  input  logic              poly_bit,
  input  logic [BYTE_W-1:0] prev_vec,
  input  logic [BYTE_W-1:0] fb_vec,
  output logic [BYTE_W-1:0] cur_vec,
  output logic              next_bit
);

  logic bit_r;
  logic bit_nxt;

  always_comb begin
    cur_vec[0] = bit_r;
    for (int k = 0; k < BYTE_W - 1; k++) begin
      cur_vec[k+1] = en & (prev_vec[k] ^ (fb_vec[k] & poly_bit));
    end
  end

  assign next_bit = en & (prev_vec[BYTE_W-1] ^ (fb_vec[BYTE_W-1] & poly_bit));

  always_comb begin
    bit_nxt = bit_r;
    if (ctl.reload) bit_nxt = start_bit;
    else if (ctl.adv) bit_nxt = next_bit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 1'b0;
    end else begin
      bit_r <= bit_nxt;
    end
  end

endmodule

// ===== rtl/pce_init_conv.sv =====
// Iterative conversion of the initial value to direct form, one shift step per cycle.
module pce_init_conv
  import pce_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [ORDER_W-1:0] order_n,
  input  logic [CRC_W-1:0]   mask,
  input  logic [CRC_W-1:0]   poly_m,
  input  logic [CRC_W-1:0]   init_m,
  input  logic               init_is_direct,
  output conv_st_t           st,
  output logic [CRC_W-1:0]   start_value
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOAD  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } conv_state_t;

  conv_state_t      state_r, state_nxt;
  logic [CRC_W-1:0] v_r, v_nxt;
  logic [TOP_W-1:0] cnt_r, cnt_nxt;
  logic [TOP_W-1:0] top_idx;
  logic             fb;

  assign top_idx = TOP_W'(order_n - 6'd1);
  assign fb      = v_r[top_idx];

  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        v_nxt     = init_m;
        cnt_nxt   = '0;
        state_nxt = init_is_direct ? S_DONE : S_SHIFT;
      end
      S_SHIFT: begin
        v_nxt   = ((v_r << 1) & mask) ^ (fb ? poly_m : '0);
        cnt_nxt = cnt_r + TOP_W'(1);
        if (cnt_r == top_idx) state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  assign st.busy     = (state_r != S_IDLE);
  assign st.done     = (state_r == S_DONE);
  assign start_value = v_r;

endmodule

// ===== rtl/parametric_crc_engine_unit.sv =====
// Top level of the parametric CRC engine: configuration, bit-slice row and output stage.
// Computes a Rocksoft-model CRC of order 1 to 32 over a byte stream, one byte per cycle
// when the output side keeps up and no start value conversion runs: the running CRC sits
// in a row of 32 bit-slice cells, and each cell forms its bit after all eight shift steps
// of the byte combinationally, so a byte enters every cycle. The CRC of a message shows
// up in the cycle after its last byte is taken, held in an output register; the input
// stalls while that register holds a result not yet taken, and while a new start value
// is formed after a write to register 0 to 6: a load step, one shift step per cycle when
// the initial value is converted, and a done step; the running CRC then restarts from it.
module parametric_crc_engine_unit
  import pce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CRC_W-1:0]  out_crc_value,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CRC_W-1:0]  cfg_data
);

  logic [ORDER_W-1:0] order_r;
  logic [CRC_W-1:0]   poly_r, init_r, fxor_r, direct_start_r;
  logic               init_direct_r, refl_in_r, refl_out_r;
  logic               out_valid_r;
  logic [CRC_W-1:0]   out_crc_r, out_crc_nxt;

  logic [ORDER_W-1:0] order_n;
  logic [CRC_W-1:0]   mask, poly_m;
  logic [TOP_W-1:0]   top_idx;
  logic [BYTE_W-1:0]  din;
  logic [BYTE_W-1:0]  cur_vec [CRC_W];
  logic [BYTE_W-1:0]  top_vec, fb_vec;
  logic [CRC_W-1:0]   crc_next, crc_rev, crc_run;
  logic               in_acc, out_acc, cfg_acc, cfg_hit;
  conv_st_t           conv_st;
  cell_ctl_t          cell_ctl;
  logic [CRC_W-1:0]   conv_value;

  assign order_n = eff_order(order_r);
  assign mask    = width_mask(order_n);
  assign poly_m  = poly_r & mask;
  assign top_idx = TOP_W'(order_n - 6'd1);

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign cfg_acc = cfg_valid && cfg_ready;
  assign cfg_hit = cfg_acc && (cfg_index <= REG_REFL_OUT);

  assign in_stall  = conv_st.busy || (out_valid_r && out_stall);
  assign cfg_ready = !conv_st.busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r       <= ORDER_RST;
      poly_r        <= POLY_RST;
      init_r        <= '0;
      init_direct_r <= 1'b1;
      fxor_r        <= '0;
      refl_in_r     <= 1'b0;
      refl_out_r    <= 1'b0;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        REG_ORDER:       order_r       <= cfg_data[ORDER_W-1:0];
        REG_POLY:        poly_r        <= cfg_data;
        REG_INIT:        init_r        <= cfg_data;
        REG_INIT_DIRECT: init_direct_r <= cfg_data[0];
        REG_FINAL_XOR:   fxor_r        <= cfg_data;
        REG_REFL_IN:     refl_in_r     <= cfg_data[0];
        REG_REFL_OUT:    refl_out_r    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  pce_init_conv u_conv (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (cfg_hit),
    .order_n        (order_n),
    .mask           (mask),
    .poly_m         (poly_m),
    .init_m         (init_r & mask),
    .init_is_direct (init_direct_r),
    .st             (conv_st),
    .start_value    (conv_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direct_start_r <= '0;
    end else if (conv_st.done) begin
      direct_start_r <= conv_value;
    end
  end

  assign din     = refl_in_r ? rev8(in_data_byte) : in_data_byte;
  assign top_vec = cur_vec[top_idx];

  always_comb begin
    for (int k = 0; k < BYTE_W; k++) begin
      fb_vec[k] = top_vec[k] ^ din[BYTE_W-1-k];
    end
  end

  assign cell_ctl.adv    = in_acc && !in_last_byte;
  assign cell_ctl.reload = (in_acc && in_last_byte) || conv_st.done;

  for (genvar i = 0; i < CRC_W; i++) begin : g_cell
    logic [BYTE_W-1:0] prev_vec;
    if (i == 0) begin : g_first
      assign prev_vec = '0;
    end else begin : g_rest
      assign prev_vec = cur_vec[i-1];
    end
    pce_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .start_bit (conv_st.done ? conv_value[i] : direct_start_r[i]),
      .en        (mask[i]),
      .poly_bit  (poly_m[i]),
      .prev_vec  (prev_vec),
      .fb_vec    (fb_vec),
      .cur_vec   (cur_vec[i]),
      .next_bit  (crc_next[i])
    );
    assign crc_run[i] = cur_vec[i][0];
  end

  assign crc_rev     = rev32(crc_next) >> (ORDER_MAX - order_n);
  assign out_crc_nxt = ((refl_out_r ? crc_rev : crc_next) ^ fxor_r) & mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_last_byte) begin
      out_crc_r <= out_crc_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> in_stall && !cfg_ready)
    else $error("input not held off after configuration write");

  a_out_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_crc_r & ~mask) == '0))
    else $error("result has bits above the CRC order");

  a_run_masked: assert property (@(posedge clk) disable iff (!rst_n)
    !conv_st.busy |-> ((crc_run & ~mask) == '0))
    else $error("running CRC has bits above the CRC order");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    conv_st.done |=> !conv_st.done && !conv_st.busy)
    else $error("start value conversion did not finish cleanly");

endmodule
